@@ rtl/mvn_pkg.sv @@
// Package for the mesh vertex normal block: payload structs, command codes
// and fixed-point constants. It depends on nothing; the top level and the testbench import it.
package mvn_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int COORD_BITS_DEF   = 16;
  localparam int SUM_BITS_DEF     = 24;

  // Command codes carried in the cmd field.
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TRI  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Normalizer constants: magnitudes are brought below 2^MAG_LIM before squaring.
  localparam int ONE_Q14   = 16384;
  localparam int Q_W       = 15;
  localparam int MAG_LIM   = 30;
  localparam int SQP_W     = 2 * MAG_LIM;
  localparam int SQ_W      = SQP_W + 2;
  localparam int LEN_W     = MAG_LIM + 1;
  localparam int DIV_STEPS = Q_W;
  localparam int NUM_W     = MAG_LIM + 14 + 1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic [9:0]         vertex_a;
    logic [9:0]         vertex_b;
    logic [9:0]         vertex_c;
  } in_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               valid_normal;
  } out_t;

endpackage

@@ rtl/mvn_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// It depends on nothing; the top level instances it for both stores.
module mvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mesh_vertex_normals.sv @@
// Top level of the mesh vertex normal block: sequencer, cross product,
// normalizer and the two store RAMs. It depends on mvn_pkg and mvn_ram.
//
//   port group   dir   handshake              payload
//   in_*         in    in_valid / in_ready    in_data  (in_t)
//   out_*        out   out_valid / out_ready  out_data (out_t)
//
// A triangle reads its corners, takes the cross product, halves the magnitudes
// (at most three times) and normalizes; a degenerate one stops before the
// halving. A read skips the normalizer for a zero sum or an index out of range;
// the 31-step square root and the 15-step divider make up most of the
// normalizer. Reset clears the sequencer and the output valid; store contents
// are undefined until loaded. A finished read waits in the output register,
// and the next transaction is taken while it waits.
module mesh_vertex_normals
  import mvn_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int SUM_BITS     = SUM_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CB = COORD_BITS;
  localparam int SB = SUM_BITS;
  localparam int EW = CB + 1;
  localparam int PW = 2 * EW;
  localparam int VW = (PW + 1 > SB) ? PW + 1 : SB;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RDS  = 5'd1;
  localparam logic [4:0] S_PA   = 5'd2;
  localparam logic [4:0] S_PB   = 5'd3;
  localparam logic [4:0] S_PC   = 5'd4;
  localparam logic [4:0] S_MUL  = 5'd5;
  localparam logic [4:0] S_ABS  = 5'd6;
  localparam logic [4:0] S_SHF  = 5'd7;
  localparam logic [4:0] S_SQ   = 5'd8;
  localparam logic [4:0] S_SQRT = 5'd9;
  localparam logic [4:0] S_LEN  = 5'd10;
  localparam logic [4:0] S_DSET = 5'd11;
  localparam logic [4:0] S_DIV  = 5'd12;
  localparam logic [4:0] S_FIN  = 5'd13;
  localparam logic [4:0] S_SRD  = 5'd14;
  localparam logic [4:0] S_SWR  = 5'd15;
  localparam logic [4:0] S_OUT  = 5'd16;

  logic [4:0]            state_r;
  logic                  is_tri_r;
  logic [AW-1:0]         idx_r [3];
  logic signed [CB-1:0]  pa_r [3];
  logic signed [CB-1:0]  pb_r [3];
  logic signed [EW-1:0]  e1_r [3];
  logic signed [EW-1:0]  e2_r [3];
  logic [4:0]            cnt_r;
  logic [1:0]            k_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [PW-1:0]  acc_r;
  logic signed [VW-1:0]  vec_r [3];
  logic [VW-1:0]         mag_r [3];
  logic                  neg_r [3];
  logic [SQP_W-1:0]      sqp_r;
  logic [SQ_W-1:0]       sq_r;
  logic [SQ_W-1:0]       res_r;
  logic [LEN_W-1:0]      len_r;
  logic [LEN_W-1:0]      rem_r [3];
  logic [DIV_STEPS-1:0]  nlo_r [3];
  logic [Q_W-1:0]        q_r [3];
  logic                  ok_r;
  logic                  out_valid_r;
  out_t                  out_data_r;

  logic                  accept;
  logic                  a_in_range;
  logic                  tri_in_range;
  logic [3*CB-1:0]       pos_rdata;
  logic [3*SB-1:0]       sum_rdata;
  logic                  pos_we;
  logic [AW-1:0]         pos_raddr;
  logic [3*CB-1:0]       pos_wdata;
  logic                  sum_we;
  logic [AW-1:0]         sum_waddr;
  logic [AW-1:0]         sum_raddr;
  logic [3*SB-1:0]       sum_wdata;
  logic [3*SB-1:0]       sum_upd;
  logic signed [EW-1:0]  mul_a;
  logic signed [EW-1:0]  mul_b;
  logic [MAG_LIM-1:0]    m30 [3];
  logic [MAG_LIM-1:0]    sq_sel;
  logic [SQ_W-1:0]       sqrt_bit;
  logic [SQ_W-1:0]       sqrt_trial;
  logic                  mag_high;
  logic                  vec_zero;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Index range checks against the store depth.
  assign a_in_range   = (32'(in_data.vertex_a) < MAX_VERTICES);
  assign tri_in_range = a_in_range && (32'(in_data.vertex_b) < MAX_VERTICES) &&
                        (32'(in_data.vertex_c) < MAX_VERTICES);

  // Position store: written by loads, read three times per triangle.
  assign pos_we    = accept && (in_data.cmd == CMD_LOAD) && a_in_range;
  assign pos_wdata = {CB'(in_data.coord_z), CB'(in_data.coord_y), CB'(in_data.coord_x)};

  always_comb begin
    unique case (state_r)
      S_IDLE:  pos_raddr = AW'(in_data.vertex_a);
      S_PA:    pos_raddr = idx_r[1];
      default: pos_raddr = idx_r[2];
    endcase
  end

  mvn_ram #(.WIDTH(3 * CB), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (AW'(in_data.vertex_a)),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  // Saturating update of the sum read back for the current corner.
  always_comb begin
    logic signed [SB:0] s;
    logic signed [15:0] delta;
    for (int i = 0; i < 3; i++) begin
      delta = neg_r[i] ? 16'(q_r[i]) : -16'(q_r[i]);
      s = (SB + 1)'($signed(sum_rdata[i*SB +: SB])) + (SB + 1)'(delta);
      if (s[SB] != s[SB-1]) begin
        sum_upd[i*SB +: SB] = s[SB] ? {1'b1, {(SB - 1){1'b0}}} : {1'b0, {(SB - 1){1'b1}}};
      end else begin
        sum_upd[i*SB +: SB] = s[SB-1:0];
      end
    end
  end

  // Sum store: cleared by loads, read-modify-written per triangle corner.
  assign sum_we    = pos_we || (state_r == S_SWR);
  assign sum_waddr = pos_we ? AW'(in_data.vertex_a) : idx_r[k_r];
  assign sum_wdata = pos_we ? '0 : sum_upd;
  assign sum_raddr = (state_r == S_IDLE) ? AW'(in_data.vertex_a) : idx_r[k_r];

  mvn_ram #(.WIDTH(3 * SB), .DEPTH(MAX_VERTICES)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  // Operand selection for the shared cross-product multiplier.
  always_comb begin
    case (cnt_r[2:0])
      3'd0:    begin mul_a = e1_r[1]; mul_b = e2_r[2]; end
      3'd1:    begin mul_a = e1_r[2]; mul_b = e2_r[1]; end
      3'd2:    begin mul_a = e1_r[2]; mul_b = e2_r[0]; end
      3'd3:    begin mul_a = e1_r[0]; mul_b = e2_r[2]; end
      3'd4:    begin mul_a = e1_r[0]; mul_b = e2_r[1]; end
      default: begin mul_a = e1_r[1]; mul_b = e2_r[0]; end
    endcase
  end

  // Normalizer helpers: reduced magnitudes, square operand, root trial.
  always_comb begin
    mag_high = 1'b0;
    vec_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      m30[i]   = MAG_LIM'(mag_r[i]);
      mag_high = mag_high || ((mag_r[i] >> MAG_LIM) != '0);
      vec_zero = vec_zero && (vec_r[i] == '0);
    end
    case (cnt_r[1:0])
      2'd0:    sq_sel = m30[0];
      2'd1:    sq_sel = m30[1];
      default: sq_sel = m30[2];
    endcase
    sqrt_bit   = SQ_W'(1) << {cnt_r, 1'b0};
    sqrt_trial = res_r + sqrt_bit;
  end

  // Output valid: set when a read result is loaded, cleared once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            idx_r[0] <= AW'(in_data.vertex_a);
            idx_r[1] <= AW'(in_data.vertex_b);
            idx_r[2] <= AW'(in_data.vertex_c);
            is_tri_r <= (in_data.cmd == CMD_TRI);
            if (in_data.cmd == CMD_TRI && tri_in_range) begin
              state_r <= S_PA;
            end else if (in_data.cmd == CMD_READ) begin
              if (a_in_range) begin
                state_r <= S_RDS;
              end else begin
                ok_r    <= 1'b0;
                for (int i = 0; i < 3; i++) begin
                  q_r[i] <= '0;
                end
                state_r <= S_OUT;
              end
            end
          end
        end
        S_RDS: begin
          for (int i = 0; i < 3; i++) begin
            vec_r[i] <= VW'($signed(sum_rdata[i*SB +: SB]));
          end
          state_r <= S_ABS;
        end
        S_PA: begin
          for (int i = 0; i < 3; i++) begin
            pa_r[i] <= pos_rdata[i*CB +: CB];
          end
          state_r <= S_PB;
        end
        S_PB: begin
          for (int i = 0; i < 3; i++) begin
            pb_r[i] <= pos_rdata[i*CB +: CB];
          end
          state_r <= S_PC;
        end
        S_PC: begin
          for (int i = 0; i < 3; i++) begin
            e1_r[i] <= EW'(pb_r[i]) - EW'(pa_r[i]);
            e2_r[i] <= EW'($signed(pos_rdata[i*CB +: CB])) - EW'(pa_r[i]);
          end
          cnt_r   <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          // One product per cycle; pairs are subtracted as they come out.
          if (cnt_r < 5'd6) begin
            prod_r <= mul_a * mul_b;
          end
          case (cnt_r[2:0])
            3'd1, 3'd3, 3'd5: acc_r <= prod_r;
            3'd2: vec_r[0] <= VW'((PW + 1)'(acc_r) - (PW + 1)'(prod_r));
            3'd4: vec_r[1] <= VW'((PW + 1)'(acc_r) - (PW + 1)'(prod_r));
            3'd6: vec_r[2] <= VW'((PW + 1)'(acc_r) - (PW + 1)'(prod_r));
            default: ;
          endcase
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd6) begin
            state_r <= S_ABS;
          end
        end
        S_ABS: begin
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= vec_r[i][VW-1];
            mag_r[i] <= vec_r[i][VW-1] ? VW'(-vec_r[i]) : VW'(vec_r[i]);
          end
          if (vec_zero) begin
            // A degenerate triangle adds nothing; a zero sum reads as zero.
            ok_r <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              q_r[i] <= '0;
            end
            state_r <= is_tri_r ? S_IDLE : S_OUT;
          end else begin
            state_r <= S_SHF;
          end
        end
        S_SHF: begin
          if (mag_high) begin
            for (int i = 0; i < 3; i++) begin
              mag_r[i] <= mag_r[i] >> 1;
            end
          end else begin
            cnt_r   <= '0;
            sq_r    <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt_r < 5'd3) begin
            sqp_r <= sq_sel * sq_sel;
          end
          if (cnt_r != 5'd0) begin
            sq_r <= sq_r + SQ_W'(sqp_r);
          end
          if (cnt_r == 5'd3) begin
            cnt_r   <= 5'(MAG_LIM);
            res_r   <= '0;
            state_r <= S_SQRT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_SQRT: begin
          // Two radicand bits per step, highest first.
          if (sq_r >= sqrt_trial) begin
            sq_r  <= sq_r - sqrt_trial;
            res_r <= (res_r >> 1) + sqrt_bit;
          end else begin
            res_r <= res_r >> 1;
          end
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            state_r <= S_LEN;
          end
        end
        S_LEN: begin
          len_r   <= (res_r == '0) ? LEN_W'(1) : LEN_W'(res_r);
          state_r <= S_DSET;
        end
        S_DSET: begin
          for (int i = 0; i < 3; i++) begin
            logic [NUM_W-1:0] num;
            num = {1'b0, m30[i], 14'd0} + NUM_W'(len_r >> 1);
            rem_r[i] <= LEN_W'(num[NUM_W-1:DIV_STEPS]);
            nlo_r[i] <= num[DIV_STEPS-1:0];
            q_r[i]   <= '0;
          end
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          // Restoring division, one quotient bit per lane per cycle.
          for (int i = 0; i < 3; i++) begin
            logic [LEN_W:0] t;
            t = {rem_r[i], nlo_r[i][DIV_STEPS-1]};
            if (t >= {1'b0, len_r}) begin
              rem_r[i] <= LEN_W'(t - {1'b0, len_r});
              q_r[i]   <= {q_r[i][Q_W-2:0], 1'b1};
            end else begin
              rem_r[i] <= LEN_W'(t);
              q_r[i]   <= {q_r[i][Q_W-2:0], 1'b0};
            end
            nlo_r[i] <= nlo_r[i] << 1;
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(DIV_STEPS - 1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          for (int i = 0; i < 3; i++) begin
            if (q_r[i] > Q_W'(ONE_Q14)) begin
              q_r[i] <= Q_W'(ONE_Q14);
            end
          end
          ok_r    <= 1'b1;
          k_r     <= '0;
          state_r <= is_tri_r ? S_SRD : S_OUT;
        end
        S_SRD: begin
          state_r <= S_SWR;
        end
        S_SWR: begin
          k_r     <= k_r + 2'd1;
          state_r <= (k_r == 2'd2) ? S_IDLE : S_SRD;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.normal_x     <= neg_r[0] ? -16'(q_r[0]) : 16'(q_r[0]);
            out_data_r.normal_y     <= neg_r[1] ? -16'(q_r[1]) : 16'(q_r[1]);
            out_data_r.normal_z     <= neg_r[2] ? -16'(q_r[2]) : 16'(q_r[2]);
            out_data_r.valid_normal <= ok_r;
            state_r                 <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The divider never yields more than one before the cap.
  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (q_r[0] <= Q_W'(ONE_Q14)) && (q_r[1] <= Q_W'(ONE_Q14)) &&
                           (q_r[2] <= Q_W'(ONE_Q14)))
    else $error("normalizer quotient above one");

  // A result without a valid normal carries a zero vector.
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.valid_normal) |->
      (out_data_r.normal_x == '0) && (out_data_r.normal_y == '0) &&
      (out_data_r.normal_z == '0))
    else $error("invalid normal with nonzero components");

  // Results only come from the output state.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside the output state");

endmodule

@@ sim/tb_mesh_vertex_normals.sv @@
// Testbench for mesh_vertex_normals: loads vertices, adds triangles and reads normals,
// checking every read against a fixed-point normal predictor. Depends on mvn_pkg and the RTL.
`timescale 1ns / 1ps

module tb_mesh_vertex_normals;
  import mvn_pkg::*;

  localparam int NVERT   = 1024;
  localparam int SUM_MAX = (1 << 23) - 1;
  localparam int SUM_MIN = -(1 << 23);
  localparam logic [1:0] CMD_NONE = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  mesh_vertex_normals dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predictor state: vertex positions and per-vertex normal sums.
  longint pos_mem[NVERT][3];
  longint sum_mem[NVERT][3];
  bit     loaded[NVERT];

  in_t  pending_q[$];
  out_t normal_q[$];
  int   errors;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_off_len;
  bit   hold_off;

  initial begin
    clk = 1'b0;
  end
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

  // Long receiver hold-off, counted in cycles once requested.
  initial begin
    hold_off = 1'b0;
    wait (hold_off_len > 0);
    hold_off = 1'b1;
    repeat (hold_off_len) @(posedge clk);
    hold_off = 1'b0;
  end

  function automatic longint isqrt_u(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  // Scale a vector to a Q1.14 unit vector; returns 0 for a zero vector.
  function automatic bit to_unit(input longint v[3], output longint n[3]);
    longint unsigned mag[3];
    longint unsigned mx;
    longint unsigned sq;
    longint unsigned len;
    longint unsigned q;
    mx = 0;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? -v[i] : v[i];
      if (mag[i] > mx) mx = mag[i];
      n[i] = 0;
    end
    if (mx == 0) return 1'b0;
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
      mx >>= 1;
    end
    for (int i = 0; i < 3; i++) sq += mag[i] * mag[i];
    len = isqrt_u(sq);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 14) + (len >> 1)) / len;
      if (q > ONE_Q14) q = ONE_Q14;
      n[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (s > SUM_MAX) return SUM_MAX;
    if (s < SUM_MIN) return SUM_MIN;
    return s;
  endfunction

  // Advance the predictor by one accepted transaction.
  task automatic predict_normals(input in_t t);
    longint e1[3];
    longint e2[3];
    longint cr[3];
    longint fn[3];
    longint nv[3];
    out_t   r;
    bit     ok;
    case (t.cmd)
      CMD_LOAD: begin
        pos_mem[t.vertex_a][0] = t.coord_x;
        pos_mem[t.vertex_a][1] = t.coord_y;
        pos_mem[t.vertex_a][2] = t.coord_z;
        for (int i = 0; i < 3; i++) sum_mem[t.vertex_a][i] = 0;
      end
      CMD_TRI: begin
        for (int i = 0; i < 3; i++) begin
          e1[i] = pos_mem[t.vertex_b][i] - pos_mem[t.vertex_a][i];
          e2[i] = pos_mem[t.vertex_c][i] - pos_mem[t.vertex_a][i];
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        if (to_unit(cr, fn)) begin
          for (int i = 0; i < 3; i++) begin
            sum_mem[t.vertex_a][i] = sat_sum(sum_mem[t.vertex_a][i], -fn[i]);
            sum_mem[t.vertex_b][i] = sat_sum(sum_mem[t.vertex_b][i], -fn[i]);
            sum_mem[t.vertex_c][i] = sat_sum(sum_mem[t.vertex_c][i], -fn[i]);
          end
        end
      end
      CMD_READ: begin
        ok = to_unit(sum_mem[t.vertex_a], nv);
        r.normal_x = nv[0][15:0];
        r.normal_y = nv[1][15:0];
        r.normal_z = nv[2][15:0];
        r.valid_normal = ok;
        normal_q.insert(normal_q.size(), r);
      end
      default: ;
    endcase
  endtask

  function automatic in_t make_cmd(logic [1:0] c, int x, int y, int z,
                                   int a, int b, int cc);
    in_t t;
    t.cmd = c;
    t.coord_x = x[15:0];
    t.coord_y = y[15:0];
    t.coord_z = z[15:0];
    t.vertex_a = a[9:0];
    t.vertex_b = b[9:0];
    t.vertex_c = cc[9:0];
    return t;
  endfunction

  // Append one transaction to the driver's pending queue.
  task automatic queue_item(in_t t);
    pending_q.insert(pending_q.size(), t);
  endtask

  // Random loaded vertex index; vertices 0..2 are always loaded.
  function automatic int pick_loaded(int span);
    int v;
    do v = $urandom_range(span - 1); while (!loaded[v]);
    return v;
  endfunction

  task automatic queue_load(int a, int x, int y, int z);
    loaded[a] = 1'b1;
    queue_item(make_cmd(CMD_LOAD, x, y, z, a, $urandom, $urandom));
  endtask

  function automatic int rand_coord(int mode);
    case (mode)
      0: return $urandom_range(0, 40) - 20;
      1: return $urandom_range(0, 2000) - 1000;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Generate one random mesh phase; small local pool keeps sums interesting.
  task automatic queue_phase(int n);
    int span;
    int mode;
    int k;
    span = ($urandom_range(0, 7) == 0) ? NVERT : $urandom_range(8, 40);
    mode = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 20) begin
        queue_load($urandom_range(span - 1), rand_coord(mode), rand_coord(mode),
                   rand_coord(mode));
      end else if (k < 65) begin
        queue_item(make_cmd(CMD_TRI, $urandom, $urandom, $urandom,
                            pick_loaded(span), pick_loaded(span),
                            pick_loaded(span)));
      end else if (k < 95) begin
        queue_item(make_cmd(CMD_READ, $urandom, $urandom, $urandom,
                            pick_loaded(span), $urandom, $urandom));
      end else begin
        queue_item(make_cmd(CMD_NONE, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || normal_q.size() != 0) @(posedge clk);
  endtask

  // Stimulus and phase sequencing.
  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_len = 0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: coordinate extremes, a big triangle, degenerate and repeated-triangle cases.
    queue_load(0, 0, 0, 0);
    queue_load(1, 32767, -32768, 0);
    queue_load(2, -32768, 0, 32767);
    queue_load(1023, 32767, 32767, -32768);
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0));
    queue_item(make_cmd(CMD_TRI, 0, 0, 0, 0, 1, 2));
    queue_item(make_cmd(CMD_TRI, 0, 0, 0, 0, 0, 2));
    queue_item(make_cmd(CMD_TRI, 0, 0, 0, 1023, 1, 2));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 1023, 0, 0));
    queue_item(make_cmd(CMD_NONE, -1, -1, -1, 1023, 1023, 1023));
    queue_load(3, 1, 0, 0);
    queue_load(4, 0, 1, 0);
    queue_load(5, 0, 0, 0);
    for (int i = 0; i < 6; i++) queue_item(make_cmd(CMD_TRI, 0, 0, 0, 5, 3, 4));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 5, 0, 0));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 2, 0, 0));
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        3: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_off_len = 600; end
      endcase
      for (int m = 0; m < 6; m++) queue_phase(60);
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Driver: presents pending transactions, predicting each as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) begin
        predict_normals(in_data);
        void'(pending_q.pop_front());
      end
      if (in_valid && !in_ready) begin
        // Hold the transaction until accepted.
      end else if (pending_q.size() > 0 &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each result transaction with the oldest expected normal.
  always @(posedge clk) begin
    out_t expd;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (normal_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", out_data);
        end else begin
          expd = normal_q.pop_front();
          if (out_data !== expd) begin
            errors++;
            if (errors <= 10) $display("normal mismatch: expected %p, got %p", expd, out_data);
          end
        end
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

endmodule
